>>> rtl/nrth_pkg.sv
// ----------------------------------------------------------------------------
// nrth_pkg: shared constants for the nearest ray/triangle hit block
// Field widths, fixed-point scales and configuration register indexes.
// ----------------------------------------------------------------------------
package nrth_pkg;

  // default vertex and hit coordinate width (signed Q8.8 at 16 bits)
  localparam int COORD_WIDTH = 16;

  // ray direction is signed Q1.14 in a 16-bit register
  localparam int RAY_W    = 16;
  localparam int RAY_FRAC = 14;

  // quotient bits kept for t; a larger t is a miss
  localparam int T_BITS = 40;

  // low chunk width of the shared multiplier's narrow operand
  localparam int CHUNK = 17;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd5;

endpackage

>>> rtl/nrth_tri_if.sv
// ----------------------------------------------------------------------------
// nrth_tri_if: triangle input channel
// Valid/ready channel carrying three vertices and the last-triangle flag.
// ----------------------------------------------------------------------------
interface nrth_tri_if #(
  parameter int COORD_WIDTH = nrth_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_a_z;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_z;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_z;
  logic                          last_triangle;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
    output ready
  );
endinterface

>>> rtl/nrth_hit_if.sv
// ----------------------------------------------------------------------------
// nrth_hit_if: nearest hit result channel
// Valid/ready channel carrying the hit flag and the nearest hit point.
// ----------------------------------------------------------------------------
interface nrth_hit_if #(
  parameter int COORD_WIDTH = nrth_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          hit_found;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;
  logic signed [COORD_WIDTH-1:0] hit_z;

  modport source (
    output valid, hit_found, hit_x, hit_y, hit_z,
    input  ready
  );
  modport sink (
    input  valid, hit_found, hit_x, hit_y, hit_z,
    output ready
  );
endinterface

>>> rtl/nearest_ray_triangle_hit.sv
// ----------------------------------------------------------------------------
// nearest_ray_triangle_hit: nearest ray/triangle hit over a mesh
// Tests each triangle against a fixed ray and keeps the nearest hit point.
// ----------------------------------------------------------------------------
// Usage:
//   Write ray direction (Q1.14) and camera origin (Q8.8) through the cfg port
//   while the block is idle. Send one triangle per beat on tri_i; the block
//   drops ready while it works on a triangle. A beat with last_triangle set
//   produces one beat on hit_o with the nearest hit since the previous result
//   (hit_found low and a zero point when nothing was hit).
//   Each triangle runs through one shared multiplier under a sequencer, plus a
//   one-bit-per-cycle restoring divider for t. A triangle that hits goes
//   through multiplier chunks, write-back and control steps and the divider
//   before ready rises again, so the next triangle waits until it is done; a
//   last triangle adds an emit step, and a miss found early returns sooner.
//   Wide operands of the edge tests go through the multiplier in two 17/18-bit
//   chunks.
//   The result sits in an output register: the next triangle is accepted
//   while it waits, and only a following last triangle stalls until hit_o
//   has taken the pending beat.
//   Reset clears the ray, the origin, the nearest-hit state and the output valid.
// ----------------------------------------------------------------------------
module nearest_ray_triangle_hit #(
  parameter int COORD_WIDTH = nrth_pkg::COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nrth_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nrth_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nrth_tri_if.sink                       tri_i,
  nrth_hit_if.source                     hit_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int RW    = nrth_pkg::RAY_W;
  localparam int RF    = nrth_pkg::RAY_FRAC;
  localparam int TB    = nrth_pkg::T_BITS;
  localparam int CK    = nrth_pkg::CHUNK;
  localparam int VW    = (CW > RW) ? CW : RW;
  localparam int EW    = CW + 1;
  localparam int WW    = CW + 2;
  localparam int DW    = VW + 1;
  localparam int NW    = 2 * CW + 2;
  localparam int CCW   = 2 * CW + 3;
  localparam int TW    = TB + 1;
  localparam int MA    = (CCW > TW) ? CCW : TW;
  localparam int BN    = (DW > WW) ? DW : WW;
  localparam int KCN   = (BN <= CK + 1) ? 1 : 1 + (BN - 2) / CK;
  localparam int KCW   = (NW <= CK + 1) ? 1 : 1 + (NW - 2) / CK;
  localparam int BX    = CK * (KCW - 1) + CK + 1;
  localparam int CKW   = (KCW > 1) ? $clog2(KCW) : 1;
  localparam int PW    = MA + CK + 1;
  localparam int AW    = (4 * CW + 8 > 58) ? 4 * CW + 8 : 58;
  localparam int XW    = AW + PW;
  localparam int DSH   = TB - RF;
  localparam int DCW   = $clog2(TB);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_POST = 3'd2;
  localparam logic [2:0] S_DCHK = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_TSET = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // work phases
  localparam logic [2:0] PH_NRM = 3'd0;
  localparam logic [2:0] PH_DEN = 3'd1;
  localparam logic [2:0] PH_NUM = 3'd2;
  localparam logic [2:0] PH_QPT = 3'd3;
  localparam logic [2:0] PH_EDG = 3'd4;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW:0] v);
    logic signed [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = {v[CW], {(CW-1){~v[CW]}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // registers
  logic        [2:0]      state_q, state_d;
  logic        [2:0]      phase_q, phase_d;
  logic        [3:0]      op_q, op_d;
  logic        [CKW-1:0]  ck_q, ck_d;
  logic        [1:0]      edge_q, edge_d;
  logic                   hit_q, hit_d;
  logic                   last_q, last_d;
  logic signed [RW-1:0]   ray_q [3];
  logic signed [RW-1:0]   ray_d [3];
  logic signed [RW-1:0]   org_q [3];
  logic signed [RW-1:0]   org_d [3];
  logic signed [CW-1:0]   va_q [3];
  logic signed [CW-1:0]   va_d [3];
  logic signed [CW-1:0]   vb_q [3];
  logic signed [CW-1:0]   vb_d [3];
  logic signed [CW-1:0]   vc_q [3];
  logic signed [CW-1:0]   vc_d [3];
  logic signed [NW-1:0]   n_q [3];
  logic signed [NW-1:0]   n_d [3];
  logic signed [CCW-1:0]  c_q [3];
  logic signed [CCW-1:0]  c_d [3];
  logic signed [CW:0]     q_q [3];
  logic signed [CW:0]     q_d [3];
  logic signed [TW-1:0]   t_q, t_d;
  logic signed [AW-1:0]   acc_q, acc_d;
  logic        [AW-1:0]   ud_q, ud_d;
  logic        [AW-1:0]   un_q, un_d;
  logic                   dneg_q, dneg_d;
  logic                   sneg_q, sneg_d;
  logic        [AW-1:0]   rem_q, rem_d;
  logic        [TB-1:0]   dvd_q, dvd_d;
  logic        [TB-1:0]   quo_q, quo_d;
  logic        [DCW-1:0]  dcnt_q, dcnt_d;
  logic                   any_hit_q, any_hit_d;
  logic        [31:0]     best_dist_q, best_dist_d;
  logic signed [CW-1:0]   best_x_q, best_x_d;
  logic signed [CW-1:0]   best_y_q, best_y_d;
  logic signed [CW-1:0]   best_z_q, best_z_d;
  logic                   ovalid_q, ovalid_d;
  logic                   ohit_q, ohit_d;
  logic signed [CW-1:0]   ox_q, ox_d;
  logic signed [CW-1:0]   oy_q, oy_d;
  logic signed [CW-1:0]   oz_q, oz_d;

  // combinational
  logic signed [EW-1:0]   e1 [3];
  logic signed [EW-1:0]   e2 [3];
  logic signed [CW-1:0]   p0 [3];
  logic signed [CW-1:0]   p1 [3];
  logic signed [EW-1:0]   ev [3];
  logic signed [WW-1:0]   wv [3];
  logic signed [EW-1:0]   uu [3];
  logic signed [WW-1:0]   vv [3];
  logic signed [DW-1:0]   dif [3];
  logic        [1:0]      kk, ix_i, ix_j, sel_a, sel_b, op2, dix;
  logic signed [MA-1:0]   aval;
  logic signed [BX-1:0]   bval;
  logic                   neg, first, endsum, wide;
  logic        [CKW-1:0]  kc_last;
  logic                   last_ck;
  logic signed [CK:0]     bch;
  logic signed [PW-1:0]   prod;
  logic signed [XW-1:0]   psh;
  logic signed [AW-1:0]   pterm, acc_base, acc_sum;
  logic        [AW-1:0]   acc_abs;
  logic signed [AW-1:0]   rnd, rsh, qw;
  logic                   q_ok;
  logic        [AW:0]     r2, rdiff;
  logic                   ge;
  logic                   too_big;
  logic        [31:0]     d32;
  logic                   emit;

  // edge vectors for the normal and for the current edge test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EW'(vb_q[i]) - EW'(va_q[i]);
      e2[i] = EW'(vc_q[i]) - EW'(va_q[i]);
      unique case (edge_q)
        2'd0: begin
          p0[i] = va_q[i];
          p1[i] = vb_q[i];
        end
        2'd1: begin
          p0[i] = vb_q[i];
          p1[i] = vc_q[i];
        end
        default: begin
          p0[i] = vc_q[i];
          p1[i] = va_q[i];
        end
      endcase
      ev[i]  = EW'(p1[i]) - EW'(p0[i]);
      wv[i]  = WW'(q_q[i]) - WW'(p0[i]);
      uu[i]  = (phase_q == PH_NRM) ? e1[i] : ev[i];
      vv[i]  = (phase_q == PH_NRM) ? WW'(e2[i]) : wv[i];
      dif[i] = DW'(va_q[i]) - DW'(org_q[i]);
    end
  end

  // cross-product term indexes
  assign kk  = op_q[2:1];
  assign op2 = op_q[1:0];
  assign dix = 2'(op_q - 4'd6);

  always_comb begin
    unique case (kk)
      2'd0: begin
        ix_i = 2'd1;
        ix_j = 2'd2;
      end
      2'd1: begin
        ix_i = 2'd2;
        ix_j = 2'd0;
      end
      2'd2: begin
        ix_i = 2'd0;
        ix_j = 2'd1;
      end
      default: begin
        ix_i = 2'd0;
        ix_j = 2'd0;
      end
    endcase
  end

  assign sel_a = op_q[0] ? ix_j : ix_i;
  assign sel_b = op_q[0] ? ix_i : ix_j;

  // operand select for the shared multiplier
  always_comb begin
    aval   = MA'(uu[sel_a]);
    bval   = BX'(vv[sel_b]);
    neg    = op_q[0];
    first  = ~op_q[0];
    endsum = op_q[0];
    wide   = 1'b0;
    unique case (phase_q)
      PH_DEN: begin
        aval   = MA'(n_q[op2]);
        bval   = BX'(ray_q[op2]);
        neg    = 1'b0;
        first  = (op_q == 4'd0);
        endsum = (op_q == 4'd2);
      end
      PH_NUM: begin
        aval   = MA'(n_q[op2]);
        bval   = BX'(dif[op2]);
        neg    = 1'b0;
        first  = (op_q == 4'd0);
        endsum = (op_q == 4'd2);
      end
      PH_QPT: begin
        aval   = MA'(t_q);
        bval   = BX'(ray_q[op2]);
        neg    = 1'b0;
        first  = 1'b1;
        endsum = 1'b1;
      end
      PH_EDG: begin
        if (op_q >= 4'd6) begin
          aval   = MA'(c_q[dix]);
          bval   = BX'(n_q[dix]);
          neg    = 1'b0;
          first  = (op_q == 4'd6);
          endsum = (op_q == 4'd8);
          wide   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // chunked multiply and accumulate
  assign kc_last = wide ? CKW'(KCW - 1) : CKW'(KCN - 1);
  assign last_ck = (ck_q == kc_last);

  always_comb begin
    if (last_ck) begin
      bch = bval[CK*ck_q +: CK+1];
    end else begin
      bch = {1'b0, bval[CK*ck_q +: CK]};
    end
  end

  assign prod     = aval * bch;
  assign psh      = XW'(prod) <<< (CK * ck_q);
  assign pterm    = psh[AW-1:0];
  assign acc_base = (first && (ck_q == '0)) ? '0 : acc_q;
  assign acc_sum  = acc_base + (neg ? -pterm : pterm);
  assign acc_abs  = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

  // round t*d to Q8.8, ties away from zero, and add the origin
  assign rnd  = acc_q + (acc_q[AW-1] ? AW'(2 ** (RF - 1) - 1) : AW'(2 ** (RF - 1)));
  assign rsh  = rnd >>> RF;
  assign qw   = rsh + AW'(org_q[op2]);
  assign q_ok = (&qw[AW-1:CW]) | ~(|qw[AW-1:CW]);

  // restoring divider step and range check
  assign r2      = {rem_q, dvd_q[TB-1]};
  assign rdiff   = r2 - {1'b0, ud_q};
  assign ge      = (r2 >= {1'b0, ud_q});
  assign too_big = ({{DSH{1'b0}}, un_q} >= {ud_q, {DSH{1'b0}}});

  assign d32  = (|quo_q[TB-1:32]) ? '1 : quo_q[31:0];
  assign emit = (state_q == S_EMIT) && (!ovalid_q || hit_o.ready);

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    ck_d        = ck_q;
    edge_d      = edge_q;
    hit_d       = hit_q;
    last_d      = last_q;
    ray_d       = ray_q;
    org_d       = org_q;
    va_d        = va_q;
    vb_d        = vb_q;
    vc_d        = vc_q;
    n_d         = n_q;
    c_d         = c_q;
    q_d         = q_q;
    t_d         = t_q;
    acc_d       = acc_q;
    ud_d        = ud_q;
    un_d        = un_q;
    dneg_d      = dneg_q;
    sneg_d      = sneg_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    any_hit_d   = any_hit_q;
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    best_z_d    = best_z_q;
    ohit_d      = ohit_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;
    ovalid_d    = ovalid_q && !hit_o.ready;

    // take configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nrth_pkg::CFG_RAY_DIR_X: ray_d[0] = cfg_data_i;
        nrth_pkg::CFG_RAY_DIR_Y: ray_d[1] = cfg_data_i;
        nrth_pkg::CFG_RAY_DIR_Z: ray_d[2] = cfg_data_i;
        nrth_pkg::CFG_ORIGIN_X:  org_d[0] = cfg_data_i;
        nrth_pkg::CFG_ORIGIN_Y:  org_d[1] = cfg_data_i;
        nrth_pkg::CFG_ORIGIN_Z:  org_d[2] = cfg_data_i;
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (tri_i.valid) begin
          va_d    = '{tri_i.vertex_a_x, tri_i.vertex_a_y, tri_i.vertex_a_z};
          vb_d    = '{tri_i.vertex_b_x, tri_i.vertex_b_y, tri_i.vertex_b_z};
          vc_d    = '{tri_i.vertex_c_x, tri_i.vertex_c_y, tri_i.vertex_c_z};
          last_d  = tri_i.last_triangle;
          phase_d = PH_NRM;
          op_d    = 4'd0;
          ck_d    = '0;
          edge_d  = 2'd0;
          hit_d   = 1'b0;
          state_d = S_MUL;
        end
      end

      // run one multiplier chunk a cycle
      S_MUL: begin
        acc_d = acc_sum;
        if (last_ck) begin
          ck_d = '0;
          if (endsum) begin
            state_d = S_POST;
          end else begin
            op_d = op_q + 4'd1;
          end
        end else begin
          ck_d = ck_q + CKW'(1);
        end
      end

      // write back a finished sum and pick the next step
      S_POST: begin
        state_d = S_MUL;
        unique case (phase_q)
          PH_NRM: begin
            n_d[kk] = acc_q[NW-1:0];
            if (op_q == 4'd5) begin
              phase_d = PH_DEN;
              op_d    = 4'd0;
            end else begin
              op_d = op_q + 4'd1;
            end
          end
          PH_DEN: begin
            ud_d    = acc_abs;
            dneg_d  = acc_q[AW-1];
            phase_d = PH_NUM;
            op_d    = 4'd0;
            if (acc_q == '0) begin
              state_d = S_FIN;
            end
          end
          PH_NUM: begin
            un_d    = acc_abs;
            sneg_d  = acc_q[AW-1] ^ dneg_q;
            state_d = S_DCHK;
          end
          PH_QPT: begin
            q_d[op2] = qw[CW:0];
            if (!q_ok) begin
              state_d = S_FIN;
            end else if (op_q == 4'd2) begin
              phase_d = PH_EDG;
              edge_d  = 2'd0;
              op_d    = 4'd0;
            end else begin
              op_d = op_q + 4'd1;
            end
          end
          PH_EDG: begin
            if (op_q < 4'd6) begin
              c_d[kk] = acc_q[CCW-1:0];
              op_d    = op_q + 4'd1;
            end else if (acc_q[AW-1]) begin
              state_d = S_FIN;
            end else if (edge_q == 2'd2) begin
              hit_d   = 1'b1;
              state_d = S_FIN;
            end else begin
              edge_d = edge_q + 2'd1;
              op_d   = 4'd0;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      // drop a t that is too large, else seed the divider
      S_DCHK: begin
        if (too_big) begin
          state_d = S_FIN;
        end else begin
          rem_d   = AW'(un_q >> DSH);
          dvd_d   = {un_q[DSH-1:0], {RF{1'b0}}};
          quo_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end

      // one quotient bit a cycle
      S_DIV: begin
        rem_d  = ge ? rdiff[AW-1:0] : r2[AW-1:0];
        quo_d  = {quo_q[TB-2:0], ge};
        dvd_d  = {dvd_q[TB-2:0], 1'b0};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(TB - 1)) begin
          state_d = S_TSET;
        end
      end

      // give t its sign and start the hit point
      S_TSET: begin
        t_d     = sneg_q ? -TW'(quo_q) : TW'(quo_q);
        phase_d = PH_QPT;
        op_d    = 4'd0;
        ck_d    = '0;
        state_d = S_MUL;
      end

      // keep the hit if strictly nearer
      S_FIN: begin
        if (hit_q && (!any_hit_q || (d32 < best_dist_q))) begin
          any_hit_d   = 1'b1;
          best_dist_d = d32;
          best_x_d    = sat_coord(q_q[0]);
          best_y_d    = sat_coord(q_q[1]);
          best_z_d    = sat_coord(q_q[2]);
        end
        state_d = last_q ? S_EMIT : S_IDLE;
      end

      // hand the result to the output register and clear
      S_EMIT: begin
        if (emit) begin
          ovalid_d    = 1'b1;
          ohit_d      = any_hit_q;
          ox_d        = best_x_q;
          oy_d        = best_y_q;
          oz_d        = best_z_q;
          any_hit_d   = 1'b0;
          best_dist_d = '0;
          best_x_d    = '0;
          best_y_d    = '0;
          best_z_d    = '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_NRM;
      op_q        <= '0;
      ck_q        <= '0;
      edge_q      <= '0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      ray_q       <= '{default: '0};
      org_q       <= '{default: '0};
      dcnt_q      <= '0;
      any_hit_q   <= 1'b0;
      best_dist_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_z_q    <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      ck_q        <= ck_d;
      edge_q      <= edge_d;
      hit_q       <= hit_d;
      last_q      <= last_d;
      ray_q       <= ray_d;
      org_q       <= org_d;
      dcnt_q      <= dcnt_d;
      any_hit_q   <= any_hit_d;
      best_dist_q <= best_dist_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
      best_z_q    <= best_z_d;
      ovalid_q    <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    va_q   <= va_d;
    vb_q   <= vb_d;
    vc_q   <= vc_d;
    n_q    <= n_d;
    c_q    <= c_d;
    q_q    <= q_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    ud_q   <= ud_d;
    un_q   <= un_d;
    dneg_q <= dneg_d;
    sneg_q <= sneg_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    ohit_q <= ohit_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
  end

  // channel outputs
  assign tri_i.ready     = (state_q == S_IDLE);
  assign hit_o.valid     = ovalid_q;
  assign hit_o.hit_found = ohit_q;
  assign hit_o.hit_x     = ox_q;
  assign hit_o.hit_y     = oy_q;
  assign hit_o.hit_z     = oz_q;

endmodule

>>> tb/sv/tb_nearest_ray_triangle_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_ray_triangle_hit: self-checking bench for the nearest hit block
// Sends meshes of triangles under several ray/origin settings, predicts the
// nearest hit per mesh in fixed point, and compares every result beat.
// ----------------------------------------------------------------------------
module tb_nearest_ray_triangle_hit;

  // register indexes with no register behind them
  localparam logic [nrth_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [nrth_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    logic signed [nrth_pkg::COORD_WIDTH-1:0] v[9];  // a xyz, b xyz, c xyz
    bit                                      last;
  } triangle_t;

  typedef struct {
    logic                                    found;
    logic signed [nrth_pkg::COORD_WIDTH-1:0] x, y, z;
  } nearest_hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [nrth_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [nrth_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  nrth_tri_if tri_bus ();
  nrth_hit_if hit_bus ();

  nearest_ray_triangle_hit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .tri_i(tri_bus), .hit_o(hit_bus)
  );

  always #10 clk_i = ~clk_i;

  triangle_t    mesh_queue[$];
  nearest_hit_t hits_due[$];
  int           mismatches = 0;
  bit           quiet = 1'b0;
  int           send_gap, recv_wait;

  // predictor state
  longint      ray[3], org[3];
  bit          any_hit;
  logic [31:0] best_dist;
  longint      best[3];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint round_q14(longint v);
    longint m;
    m = ((v < 0 ? -v : v) + 64'sd8192) >>> 14;
    return v < 0 ? -m : m;
  endfunction

  function automatic bit edge_nonneg(input longint p0[3], input longint p1[3],
                                     input longint q[3], input longint n[3]);
    longint e[3], w[3], c[3];
    logic signed [127:0] acc, cc, nn;
    for (int i = 0; i < 3; i++) begin
      e[i] = p1[i] - p0[i];
      w[i] = q[i] - p0[i];
    end
    c[0] = e[1] * w[2] - e[2] * w[1];
    c[1] = e[2] * w[0] - e[0] * w[2];
    c[2] = e[0] * w[1] - e[1] * w[0];
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      cc = c[i];
      nn = n[i];
      acc = acc + cc * nn;
    end
    return !acc[127];
  endfunction

  function automatic bit triangle_hits(input longint a[3], input longint b[3],
                                       input longint c[3], output logic [39:0] t_mag,
                                       output longint q[3]);
    longint e1[3], e2[3], n[3], den, num, t;
    logic [127:0] numer, quo;
    t_mag = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      q[i] = 0;
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    den = n[0] * ray[0] + n[1] * ray[1] + n[2] * ray[2];
    if (den == 0) return 0;
    num = n[0] * (a[0] - org[0]) + n[1] * (a[1] - org[1]) + n[2] * (a[2] - org[2]);
    numer = 128'(num < 0 ? -num : num) << nrth_pkg::RAY_FRAC;
    quo = numer / 128'(den < 0 ? -den : den);
    if (quo >= (128'd1 << nrth_pkg::T_BITS)) return 0;
    t = ((num < 0) != (den < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    for (int i = 0; i < 3; i++) begin
      q[i] = org[i] + round_q14(t * ray[i]);
      if (q[i] < -(64'sd1 << nrth_pkg::COORD_WIDTH) ||
          q[i] >= (64'sd1 << nrth_pkg::COORD_WIDTH)) return 0;
    end
    if (!edge_nonneg(a, b, q, n) || !edge_nonneg(b, c, q, n) || !edge_nonneg(c, a, q, n))
      return 0;
    t_mag = quo[39:0];
    return 1;
  endfunction

  function automatic longint clamp_coord(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic void track_nearest(triangle_t it);
    longint a[3], b[3], c[3], q[3];
    logic [39:0] t_mag;
    logic [31:0] d32;
    nearest_hit_t h;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.v[i];
      b[i] = it.v[3 + i];
      c[i] = it.v[6 + i];
    end
    if (triangle_hits(a, b, c, t_mag, q)) begin
      d32 = (t_mag > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : t_mag[31:0];
      if (!any_hit || d32 < best_dist) begin
        any_hit = 1;
        best_dist = d32;
        for (int i = 0; i < 3; i++) best[i] = clamp_coord(q[i]);
      end
    end
    if (it.last) begin
      h.found = any_hit;
      h.x = any_hit ? nrth_pkg::COORD_WIDTH'(best[0]) : '0;
      h.y = any_hit ? nrth_pkg::COORD_WIDTH'(best[1]) : '0;
      h.z = any_hit ? nrth_pkg::COORD_WIDTH'(best[2]) : '0;
      hits_due = {hits_due, h};
      any_hit = 0;
      best_dist = 0;
      best = '{0, 0, 0};
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // drive triangle beats from the mesh queue
  always @(posedge clk_i or negedge rst_ni) begin
    triangle_t it;
    if (!rst_ni) begin
      tri_bus.valid <= 1'b0;
      tri_bus.last_triangle <= 1'b0;
      {tri_bus.vertex_a_x, tri_bus.vertex_a_y, tri_bus.vertex_a_z} <= '0;
      {tri_bus.vertex_b_x, tri_bus.vertex_b_y, tri_bus.vertex_b_z} <= '0;
      {tri_bus.vertex_c_x, tri_bus.vertex_c_y, tri_bus.vertex_c_z} <= '0;
      send_gap <= 0;
    end else if (!tri_bus.valid || tri_bus.ready) begin
      if (send_gap == 0 && mesh_queue.size() > 0) begin
        it = mesh_queue.pop_front();
        tri_bus.vertex_a_x <= it.v[0];
        tri_bus.vertex_a_y <= it.v[1];
        tri_bus.vertex_a_z <= it.v[2];
        tri_bus.vertex_b_x <= it.v[3];
        tri_bus.vertex_b_y <= it.v[4];
        tri_bus.vertex_b_z <= it.v[5];
        tri_bus.vertex_c_x <= it.v[6];
        tri_bus.vertex_c_y <= it.v[7];
        tri_bus.vertex_c_z <= it.v[8];
        tri_bus.last_triangle <= it.last;
        tri_bus.valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        tri_bus.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end
    end
  end

  // random backpressure on the result channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_bus.ready <= 1'b0;
      recv_wait <= 0;
    end else if (recv_wait > 0) begin
      hit_bus.ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      hit_bus.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) recv_wait <= pick_gap();
    end
  end

  // predict on accepted triangles, check accepted results
  always @(posedge clk_i) begin
    triangle_t it;
    nearest_hit_t want;
    if (rst_ni) begin
      if (tri_bus.valid && tri_bus.ready) begin
        it.v = '{tri_bus.vertex_a_x, tri_bus.vertex_a_y, tri_bus.vertex_a_z,
                 tri_bus.vertex_b_x, tri_bus.vertex_b_y, tri_bus.vertex_b_z,
                 tri_bus.vertex_c_x, tri_bus.vertex_c_y, tri_bus.vertex_c_z};
        it.last = tri_bus.last_triangle;
        track_nearest(it);
      end
      if (hit_bus.valid && hit_bus.ready) begin
        if (hits_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = hits_due.pop_front();
          if (hit_bus.hit_found !== want.found)
            report_mismatch("hit_found", hit_bus.hit_found, want.found);
          if (hit_bus.hit_x !== want.x) report_mismatch("hit_x", hit_bus.hit_x, want.x);
          if (hit_bus.hit_y !== want.y) report_mismatch("hit_y", hit_bus.hit_y, want.y);
          if (hit_bus.hit_z !== want.z) report_mismatch("hit_z", hit_bus.hit_z, want.z);
        end
      end
    end
  end

  task automatic write_reg(logic [nrth_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      nrth_pkg::CFG_RAY_DIR_X: ray[0] = $signed(val);
      nrth_pkg::CFG_RAY_DIR_Y: ray[1] = $signed(val);
      nrth_pkg::CFG_RAY_DIR_Z: ray[2] = $signed(val);
      nrth_pkg::CFG_ORIGIN_X:  org[0] = $signed(val);
      nrth_pkg::CFG_ORIGIN_Y:  org[1] = $signed(val);
      nrth_pkg::CFG_ORIGIN_Z:  org[2] = $signed(val);
      default: ;
    endcase
  endtask

  task automatic set_ray(int dx, int dy, int dz, int ox, int oy, int oz);
    write_reg(nrth_pkg::CFG_RAY_DIR_X, dx[15:0]);
    write_reg(nrth_pkg::CFG_RAY_DIR_Y, dy[15:0]);
    write_reg(nrth_pkg::CFG_RAY_DIR_Z, dz[15:0]);
    write_reg(nrth_pkg::CFG_ORIGIN_X, ox[15:0]);
    write_reg(nrth_pkg::CFG_ORIGIN_Y, oy[15:0]);
    write_reg(nrth_pkg::CFG_ORIGIN_Z, oz[15:0]);
  endtask

  task automatic add_triangle(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz, bit last);
    triangle_t it;
    it.v = '{ax[15:0], ay[15:0], az[15:0], bx[15:0], by[15:0], bz[15:0],
             cx[15:0], cy[15:0], cz[15:0]};
    it.last = last;
    mesh_queue = {mesh_queue, it};
  endtask

  // mostly triangles around a point on the ray, some pure noise
  task automatic add_mesh(int count);
    triangle_t it;
    longint p[3], u1[3], u2[3];
    int s, spread;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        s = $urandom_range(0, 9) == 0 ? -int'($urandom_range(0, 4000))
                                      : int'($urandom_range(0, 9000));
        spread = $urandom_range(0, 2) == 0 ? 64 : ($urandom_range(0, 1) ? 1024 : 6000);
        for (int i = 0; i < 3; i++) begin
          p[i] = org[i] + ((longint'(s) * ray[i]) >>> nrth_pkg::RAY_FRAC);
          u1[i] = $signed($urandom_range(0, 2 * spread)) - spread;
          u2[i] = $signed($urandom_range(0, 2 * spread)) - spread;
          it.v[i] = nrth_pkg::COORD_WIDTH'(clamp_coord(p[i] + u1[i]));
          it.v[3 + i] = nrth_pkg::COORD_WIDTH'(clamp_coord(p[i] + u2[i]));
          it.v[6 + i] = nrth_pkg::COORD_WIDTH'(clamp_coord(p[i] - u1[i] - u2[i]));
        end
      end else begin
        for (int i = 0; i < 9; i++) it.v[i] = 16'($urandom);
      end
      it.last = (k == count - 1);
      mesh_queue = {mesh_queue, it};
    end
  endtask

  // wait until every triangle is taken and every result checked
  task automatic drain();
    do @(negedge clk_i);
    while (mesh_queue.size() != 0 || hits_due.size() != 0 || tri_bus.valid ||
           hit_bus.valid);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    int dir[3];
    ray = '{0, 0, 0};
    org = '{0, 0, 0};
    any_hit = 0;
    best_dist = 0;
    best = '{0, 0, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ray along +z from the origin
    set_ray(0, 0, 16384, 0, 0, 0);
    add_triangle(-512, -512, 256, 512, -512, 256, 0, 512, 256, 1);      // plain hit
    add_triangle(-512, -512, 256, 0, 512, 256, 512, -512, 256, 1);      // other winding
    add_triangle(-512, -512, 0, 512, -512, 256, 0, 512, 512, 0);        // tilted
    add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);                         // degenerate
    add_triangle(0, -512, -512, 0, 512, -512, 0, 0, 512, 1);            // parallel to ray
    add_triangle(100, 100, 256, 900, 100, 256, 100, 900, 256, 1);       // plane hit, outside
    add_triangle(-512, -512, 1024, 512, -512, 1024, 0, 512, 1024, 0);   // far
    add_triangle(-512, -512, 256, 512, -512, 256, 0, 512, 256, 0);      // nearer
    add_triangle(-600, -600, 256, 600, -600, 256, 0, 600, 256, 0);      // equal distance
    add_triangle(-512, -512, -128, 512, -512, -128, 0, 512, -128, 1);   // nearer behind
    add_triangle(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1);
    add_triangle(-32768, -32768, -32768, 32767, -32768, -32768, 0, 32767, -32768, 1);
    add_triangle(-32768, 32767, 32767, 32767, -32768, 32767, 1, 1, 32767, 1);
    add_triangle(-1, -1, 32767, 1, -1, 32767, 0, 1, 32766, 1);          // steep, huge t
    add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);                         // empty mesh
    drain();

    // directed: saturated hit point, ray along -x from the far corner
    set_ray(-16384, 0, 0, 32767, 0, 0);
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    add_triangle(-32768, -512, -512, -32768, 512, -512, -32768, 0, 512, 1);
    add_triangle(-200, -512, -512, -200, 512, -512, -200, 0, 512, 1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3);
      case (ph % 6)
        0: set_ray(0, 0, 16384, $urandom_range(0, 2000) - 1000, 0, -2000);
        1: set_ray(11585, -11585, 0, 0, 0, 0);
        2: set_ray(9459, 9459, -9459, 4000, -4000, 4000);
        3: set_ray(16384, -16384, 16384, -32768, 32767, -32768);
        4: begin
          for (int i = 0; i < 3; i++) dir[i] = $urandom_range(0, 32768) - 16384;
          set_ray(dir[0], dir[1], dir[2], $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
        default: set_ray(ph == 5 ? 0 : 32767, ph == 5 ? 0 : -32768, 0, 0, 0, 0);
      endcase
      for (int n = 0; n < 60; n += 0) begin
        dir[0] = $urandom_range(1, 8);
        add_mesh(dir[0]);
        n += dir[0];
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("nearest_ray_triangle_hit: match");
    end else begin
      $display("nearest_ray_triangle_hit: mismatch");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("nearest_ray_triangle_hit: mismatch");
    $finish;
  end

endmodule
